FILE: rtl/ols_pkg.sv
package ols_pkg;

   // list capacity and derived widths
   localparam int DEPTH = 128;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = 8;
   localparam int DW    = 32;

   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_LOCATE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS,
      S_INS_DRAIN,
      S_INS_PUT,
      S_DEL,
      S_DEL_DRAIN,
      S_READ,
      S_READ_WAIT,
      S_LOC,
      S_LOC_DRAIN,
      S_RESP
   } state_type;

   // write request into the entry store
   typedef struct packed {
      logic          en;
      logic [AW-1:0] addr;
      logic [DW-1:0] data;
   } ram_wr_type;

endpackage

FILE: rtl/ols_ram.sv
module ols_ram
   import ols_pkg::*;
(
   input  logic          clock,
   input  ram_wr_type    wr,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ordered_list_store.sv
// Insert moves the entries from the position upward up one place (none when appending at the tail),
//   delete moves the entries above the position down one place, read fetches one entry, locate
//   searches from the first entry, failed actions answer at once; every result is held until taken.
// Throughput: one word at a time; the store is walked one entry per cycle through
//   its single read port and single write port.
// Reset: synchronous, clears the count and the sequencer; the store keeps its contents.
module ordered_list_store
   import ols_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_action,
   input  logic [7:0]           req_position,
   input  logic signed [31:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ok,
   output logic signed [31:0]   rsp_data,
   output logic [7:0]           rsp_found_position,
   output logic [7:0]           rsp_count,
   output logic                 rsp_empty_res
);

   state_type     state_ff, state_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [DW-1:0] val_ff, val_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic          rdv_ff, rdv_in;
   logic [AW-1:0] rd_from_ff, rd_from_in;
   logic          ok_ff, ok_in;
   logic [DW-1:0] data_ff, data_in;
   logic [CW-1:0] found_ff, found_in;

   ram_wr_type    wr;
   logic [AW-1:0] rd_addr;
   logic [DW-1:0] rd_data;

   logic [AW-1:0] pos_m1;
   logic [AW-1:0] last_idx;
   logic          hit;
   logic [CW:0]   req_pos_x;
   logic [CW:0]   count_x;

   ols_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared helpers
   assign pos_m1    = AW'(pos_ff - CW'(1));
   assign last_idx  = AW'(count_ff - CW'(1));
   assign hit       = (rd_data == val_ff);
   assign req_pos_x = {1'b0, req_position};
   assign count_x   = {1'b0, count_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdv_ff   <= rdv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      cur_ff     <= cur_in;
      rd_from_ff <= rd_from_in;
      ok_ff      <= ok_in;
      data_ff    <= data_in;
      found_ff   <= found_in;
   end

   // sequencer: next state, store access and result
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      rdv_in     = 1'b0;
      rd_from_in = cur_ff;
      ok_in      = ok_ff;
      data_in    = data_ff;
      found_in   = found_ff;
      rd_addr    = cur_ff;
      wr         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in   = req_position;
               val_in   = req_value;
               ok_in    = 1'b0;
               data_in  = '0;
               found_in = '0;
               state_in = S_RESP;
               case (action_type'(req_action))
                  ACT_INSERT: begin
                     if (req_position != '0 && req_pos_x <= count_x + (CW+1)'(1)
                         && count_ff < DEPTH_CNT) begin
                        if (req_position - CW'(1) == count_ff) begin
                           state_in = S_INS_PUT;
                        end else begin
                           cur_in   = AW'(count_ff - CW'(1));
                           state_in = S_INS;
                        end
                     end
                  end
                  ACT_DELETE: begin
                     if (req_position != '0 && req_position <= count_ff) begin
                        cur_in   = AW'(req_position - CW'(1));
                        state_in = S_DEL;
                     end
                  end
                  ACT_READ: begin
                     if (req_position != '0 && req_position <= count_ff) begin
                        cur_in   = AW'(req_position - CW'(1));
                        state_in = S_READ;
                     end else begin
                        data_in = '1;
                     end
                  end
                  ACT_LOCATE: begin
                     ok_in = 1'b1;
                     if (count_ff != '0) begin
                        cur_in   = '0;
                        state_in = S_LOC;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // walk down from the top entry, each word moves up one place
         S_INS: begin
            rdv_in = 1'b1;
            if (rdv_ff) begin
               wr = '{en: 1'b1, addr: AW'(rd_from_ff + AW'(1)), data: rd_data};
            end
            if (cur_ff == pos_m1) begin
               state_in = S_INS_DRAIN;
            end else begin
               cur_in = cur_ff - AW'(1);
            end
         end

         S_INS_DRAIN: begin
            wr       = '{en: 1'b1, addr: AW'(rd_from_ff + AW'(1)), data: rd_data};
            state_in = S_INS_PUT;
         end

         S_INS_PUT: begin
            wr       = '{en: 1'b1, addr: pos_m1, data: val_ff};
            count_in = count_ff + CW'(1);
            ok_in    = 1'b1;
            state_in = S_RESP;
         end

         // first read is the removed word, later ones move down one place
         S_DEL: begin
            rdv_in = 1'b1;
            if (rdv_ff) begin
               if (rd_from_ff == pos_m1) begin
                  data_in = rd_data;
               end else begin
                  wr = '{en: 1'b1, addr: AW'(rd_from_ff - AW'(1)), data: rd_data};
               end
            end
            if (cur_ff == last_idx) begin
               state_in = S_DEL_DRAIN;
            end else begin
               cur_in = cur_ff + AW'(1);
            end
         end

         S_DEL_DRAIN: begin
            if (rd_from_ff == pos_m1) begin
               data_in = rd_data;
            end else begin
               wr = '{en: 1'b1, addr: AW'(rd_from_ff - AW'(1)), data: rd_data};
            end
            count_in = count_ff - CW'(1);
            ok_in    = 1'b1;
            state_in = S_RESP;
         end

         S_READ: begin
            state_in = S_READ_WAIT;
         end

         S_READ_WAIT: begin
            data_in  = rd_data;
            ok_in    = 1'b1;
            state_in = S_RESP;
         end

         // linear search, stop at the first match
         S_LOC: begin
            rdv_in = 1'b1;
            if (rdv_ff && hit) begin
               found_in = CW'(rd_from_ff) + CW'(1);
               rdv_in   = 1'b0;
               state_in = S_RESP;
            end else if (cur_ff == last_idx) begin
               state_in = S_LOC_DRAIN;
            end else begin
               cur_in = cur_ff + AW'(1);
            end
         end

         S_LOC_DRAIN: begin
            if (hit) begin
               found_in = CW'(rd_from_ff) + CW'(1);
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // handshake and result word
   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_ok             = ok_ff;
   assign rsp_data           = data_ff;
   assign rsp_found_position = found_ff;
   assign rsp_count          = count_ff;
   assign rsp_empty_res      = (count_ff == '0);

endmodule
